FILE: rtl/core/cbe_pkg.sv
// shared types and constants for the cubic bezier easing evaluator
`timescale 1ns / 1ps
package cbe_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int ONE_INT   = 1 << FRAC_BITS;

  // field widths
  localparam int X_W    = 17;  // unsigned q.16 in [0, one]
  localparam int Y_W    = 19;  // signed q3.16
  localparam int VAL_W  = 32;  // signed q16.16
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  // arithmetic widths
  localparam int COEF_W  = 24;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = 40;
  localparam int DEN_W   = 26;
  localparam int QUO_W   = NUM_W + 2;

  // default sizes
  localparam int SAMPLE_COUNT_DEF      = 11;
  localparam int NEWTON_ITERATIONS_DEF = 4;
  localparam int BISECT_ITERATIONS_DEF = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_X1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_Y1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_X2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_Y2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOPE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SCAN_RD,
    ST_SCAN_PREV,
    ST_SCAN,
    ST_GUESS_MUL,
    ST_GUESS_DS,
    ST_GUESS_DW,
    ST_SLOPE0,
    ST_NT_SLOPE,
    ST_NT_CURVE,
    ST_NT_DW,
    ST_BI_CURVE,
    ST_Y_CURVE,
    ST_OUT_MUL,
    ST_OUT_SUM
  } state_e;

endpackage

FILE: rtl/core/cbe_stream_if.sv
// valid/ready channels for progress input and eased value output
`timescale 1ns / 1ps
interface cbe_in_if;
  logic              valid;
  logic              ready;
  logic signed [18:0] progress;
  modport source (output valid, output progress, input ready);
  modport sink (input valid, input progress, output ready);
endinterface

interface cbe_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] eased_value;
  modport source (output valid, output eased_value, input ready);
  modport sink (input valid, input eased_value, output ready);
endinterface

FILE: rtl/core/cbe_mul.sv
// shared signed multiplier with optional q.16 rounding, registered result
`timescale 1ns / 1ps
module cbe_mul import cbe_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  input  logic                      rnd_i,
  output logic signed [MUL_P_W-1:0] res_o
);

  localparam logic signed [MUL_P_W-1:0] RND_C = MUL_P_W'(ONE_INT / 2);

  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] rounded;
  logic signed [MUL_P_W-1:0] res_q;

  assign prod    = a_i * b_i;
  // nearest, ties toward +inf
  assign rounded = (prod + RND_C) >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    res_q <= rnd_i ? rounded : prod;
  end

  assign res_o = res_q;

endmodule

FILE: rtl/core/cbe_div.sv
// radix-2 restoring divider giving a rounded signed quotient
`timescale 1ns / 1ps
module cbe_div import cbe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic signed [NUM_W:0]   nn;
  logic signed [DEN_W:0]   dd;
  logic signed [QUO_W-1:0] big_n;
  logic [DEN_W+1:0]        d2;
  logic [QUO_W-1:0]        mag;
  logic [DEN_W+2:0]        trial;
  logic                    ge;
  logic [DEN_W+2:0]        rem_d;

  logic [QUO_W-1:0] quo_q;
  logic [DEN_W+2:0] rem_q;
  logic [DEN_W+1:0] d_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // round(n/d) = floor((2n+d)/(2d)) with d made positive
  always_comb begin
    nn = {num_i[NUM_W-1], num_i};
    dd = {den_i[DEN_W-1], den_i};
    if (den_i[DEN_W-1]) begin
      nn = -nn;
      dd = -dd;
    end
    d2    = {dd[DEN_W:0], 1'b0};
    big_n = QUO_W'({nn, 1'b0}) + QUO_W'(dd);
    if (big_n[QUO_W-1]) begin
      mag = QUO_W'(-big_n) + QUO_W'(d2) - QUO_W'(1);
    end else begin
      mag = big_n;
    end
    trial = {rem_q[DEN_W+1:0], quo_q[QUO_W-1]};
    ge    = trial >= {1'b0, d_q};
    rem_d = ge ? trial - {1'b0, d_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      d_q   <= d2;
      neg_q <= big_n[QUO_W-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/core/cubic_bezier_easing_evaluator.sv
// cubic bezier easing evaluator top level: sequencer, sample table and config
`timescale 1ns / 1ps
// t outside (0,1) goes from the first table read straight to the output sum; otherwise a
//   table scan and a guess divide, then up to NEWTON_ITERATIONS steps of two polynomial
//   passes and a divide, or up to BISECT_ITERATIONS curve passes
// one beat at a time: a new beat is taken only in idle, and the multiplier and serial divider are shared
// a config write marks the table stale, so the next beat first rebuilds all SAMPLE_COUNT entries
// reset clears the config registers to their defaults and marks the table stale
module cubic_bezier_easing_evaluator import cbe_pkg::*; #(
  parameter int SAMPLE_COUNT      = SAMPLE_COUNT_DEF,
  parameter int NEWTON_ITERATIONS = NEWTON_ITERATIONS_DEF,
  parameter int BISECT_ITERATIONS = BISECT_ITERATIONS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cbe_in_if.sink               in_ch,
  cbe_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int IW    = $clog2(SAMPLE_COUNT);
  localparam int RW    = $clog2(SAMPLE_COUNT) + 1;
  localparam int SEGS  = SAMPLE_COUNT - 1;
  localparam int STEP_Q = ONE_INT / SEGS;
  localparam int STEP_R = ONE_INT % SEGS;
  localparam int ITMAX = (NEWTON_ITERATIONS > BISECT_ITERATIONS) ?
                         NEWTON_ITERATIONS : BISECT_ITERATIONS;
  localparam int ITW   = $clog2(ITMAX + 1);

  localparam logic [X_W-1:0]           ONE_X  = X_W'(ONE_INT);
  localparam logic signed [Y_W-1:0]    ONE_T  = Y_W'(ONE_INT);
  localparam logic signed [COEF_W-1:0] ONE_C  = COEF_W'(ONE_INT);
  localparam logic signed [41:0]       MAX32  = 42'sd2147483647;
  localparam logic signed [41:0]       MIN32  = -42'sd2147483648;

  // config registers
  logic [X_W-1:0]          x1_q, x2_q, minsl_q, prec_q;
  logic signed [Y_W-1:0]   y1_q, y2_q;
  logic signed [VAL_W-1:0] start_q, delta_q;
  logic                    tab_valid_q;

  // sequencer state
  state_e                  state_q, state_d;
  logic [1:0]              ps_q, ps_d;
  logic [IW-1:0]           idx_q;
  logic [X_W-1:0]          g_q, glo_q, prev_q, rdata_q;
  logic [RW-1:0]           gr_q;
  logic [X_W-1:0]          tab_lo_q, tab_hi_q, lo_q, hi_q;
  logic signed [Y_W-1:0]   x_q;
  logic signed [17:0]      u_q, ba_q, bb_q;
  logic signed [DEN_W-1:0] s_q;
  logic [ITW-1:0]          it_q;
  logic signed [23:0]      y_q;
  logic [VAL_W-1:0]        out_q;
  logic                    out_valid_q;

  logic [X_W-1:0] tab_mem [SAMPLE_COUNT];

  // curve coefficients, a u^3 + b u^2 + c u form
  logic [X_W-1:0]           ex1, ex2;
  logic signed [COEF_W-1:0] px1, px2, py1, py2;
  logic signed [COEF_W-1:0] ax, bx, cx, ay, by, cy;

  always_comb begin
    ex1 = (x1_q > ONE_X) ? ONE_X : x1_q;
    ex2 = (x2_q > ONE_X) ? ONE_X : x2_q;
    px1 = $signed(COEF_W'(ex1));
    px2 = $signed(COEF_W'(ex2));
    py1 = COEF_W'(y1_q);
    py2 = COEF_W'(y2_q);
    ax  = COEF_W'(ONE_C - 3 * px2 + 3 * px1);
    bx  = COEF_W'(3 * px2 - 6 * px1);
    cx  = COEF_W'(3 * px1);
    ay  = COEF_W'(ONE_C - 3 * py2 + 3 * py1);
    by  = COEF_W'(3 * py2 - 6 * py1);
    cy  = COEF_W'(3 * py1);
  end

  // shared multiplier and divider
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_rnd;
  logic signed [MUL_P_W-1:0] mul_res;
  logic signed [MUL_A_W-1:0] mr;

  cbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_i (mul_rnd),
    .res_o (mul_res)
  );

  assign mr = mul_res[MUL_A_W-1:0];

  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic signed [QUO_W-1:0] div_quo;

  cbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // polynomial pass: horner over a, b, c with one multiply per cycle
  logic                      poly_y, poly_slope, poly_done;
  logic signed [MUL_B_W-1:0] poly_u;
  logic signed [COEF_W-1:0]  ca, cb, cc;
  logic signed [MUL_A_W-1:0] poly_val;
  logic signed [MUL_A_W-1:0] poly_a;

  always_comb begin
    poly_y     = (state_q == ST_Y_CURVE);
    poly_slope = (state_q == ST_SLOPE0) || (state_q == ST_NT_SLOPE);
    poly_u     = (state_q == ST_BUILD) ? $signed(MUL_B_W'(g_q)) : MUL_B_W'(u_q);
    ca = poly_y ? ay : ax;
    cb = poly_y ? by : bx;
    cc = poly_y ? cy : cx;
    if (poly_slope) begin
      ca = COEF_W'(3 * ca);
      cb = COEF_W'(2 * cb);
    end
    poly_done = 1'b0;
    poly_val  = mr;
    poly_a    = MUL_A_W'(ca);
    case (ps_q)
      2'd0: poly_a = MUL_A_W'(ca);
      2'd1: poly_a = mr + MUL_A_W'(cb);
      2'd2: begin
        poly_a = mr + MUL_A_W'(cc);
        if (poly_slope) begin
          poly_done = 1'b1;
          poly_val  = mr + MUL_A_W'(cc);
        end
      end
      default: begin
        poly_done = 1'b1;
        poly_val  = mr;
      end
    endcase
  end

  // grid point stepping: floor(i*one/SEGS) without a divider
  logic [RW-1:0]  gsum, gr_next;
  logic           gcarry;
  logic [X_W-1:0] g_next;

  always_comb begin
    gsum    = gr_q + RW'(STEP_R);
    gcarry  = gsum >= RW'(SEGS);
    gr_next = gcarry ? gsum - RW'(SEGS) : gsum;
    g_next  = g_q + X_W'(STEP_Q) + X_W'(gcarry);
  end

  // derived values
  logic signed [33:0] cxv, absc;
  logic               x_mid, x_low, x_high;
  logic [X_W-1:0]     build_w;
  logic signed [17:0] tab_den;
  logic signed [17:0] na, nb, nct, first_ct;
  logic               bi_gt, bi_cont;
  logic signed [42:0] u_new_w;
  logic signed [17:0] u_new;
  logic signed [17:0] guess;
  logic signed [41:0] addend, sum;
  logic [VAL_W-1:0]   result;
  logic [IW-1:0]      rd_addr;
  logic               sample_gt;

  always_comb begin
    x_low  = (x_q <= Y_W'(0));
    x_high = (x_q >= ONE_T);
    x_mid  = !x_low && !x_high;
    cxv    = 34'(poly_val) - 34'(x_q);
    absc   = cxv[33] ? -cxv : cxv;
    if (poly_val < 0) begin
      build_w = '0;
    end else if (poly_val > MUL_A_W'(ONE_INT)) begin
      build_w = ONE_X;
    end else begin
      build_w = poly_val[X_W-1:0];
    end
    tab_den = $signed({1'b0, tab_hi_q}) - $signed({1'b0, tab_lo_q});
    if (tab_den == 18'sd0) begin
      tab_den = 18'sd1;
    end
    // bisection bracket update
    bi_gt   = cxv > 34'sd0;
    na      = bi_gt ? ba_q : u_q;
    nb      = bi_gt ? u_q : bb_q;
    nct     = na + ((nb - na) >>> 1);
    bi_cont = (absc > $signed(34'(prec_q))) &&
              ((it_q + ITW'(1)) < ITW'(BISECT_ITERATIONS));
    first_ct = $signed({1'b0, lo_q}) +
               (($signed({1'b0, hi_q}) - $signed({1'b0, lo_q})) >>> 1);
    // newton update with clamp to the unit range
    u_new_w = 43'(u_q) - 43'(div_quo);
    if (u_new_w < 0) begin
      u_new = '0;
    end else if (u_new_w > 43'(ONE_INT)) begin
      u_new = 18'(ONE_INT);
    end else begin
      u_new = u_new_w[17:0];
    end
    guess = $signed({1'b0, lo_q}) + div_quo[17:0];
    // output sum with saturation
    if (x_low) begin
      addend = '0;
    end else if (x_high) begin
      addend = 42'(delta_q);
    end else begin
      addend = mul_res[41:0];
    end
    sum = 42'(start_q) + addend;
    if (sum > MAX32) begin
      result = 32'h7fff_ffff;
    end else if (sum < MIN32) begin
      result = 32'h8000_0000;
    end else begin
      result = sum[VAL_W-1:0];
    end
    sample_gt = $signed({2'b00, rdata_q}) > x_q;
    unique case (state_q)
      ST_SCAN_RD:   rd_addr = '0;
      ST_SCAN_PREV: rd_addr = IW'(1);
      default:      rd_addr = (idx_q == IW'(SAMPLE_COUNT - 1)) ? idx_q : idx_q + IW'(1);
    endcase
  end

  // main sequencer
  logic in_acc, out_take, out_load, mem_we, tab_set;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  always_comb begin
    state_d   = state_q;
    ps_d      = 2'd0;
    mul_a     = poly_a;
    mul_b     = poly_u;
    mul_rnd   = 1'b1;
    div_start = 1'b0;
    div_num   = {cxv[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    div_den   = s_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    tab_set   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!tab_valid_q) begin
            state_d = ST_BUILD;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_BUILD: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done) begin
          mem_we = 1'b1;
          if (idx_q == IW'(SAMPLE_COUNT - 1)) begin
            tab_set = 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = x_mid ? ST_SCAN_PREV : ST_OUT_SUM;
      end
      ST_SCAN_PREV: state_d = ST_SCAN;
      ST_SCAN: begin
        if (idx_q == IW'(SAMPLE_COUNT - 1) || sample_gt) begin
          state_d = ST_GUESS_MUL;
        end
      end
      ST_GUESS_MUL: begin
        mul_a   = MUL_A_W'(x_q - $signed({2'b00, tab_lo_q}));
        mul_b   = MUL_B_W'($signed({1'b0, hi_q}) - $signed({1'b0, lo_q}));
        mul_rnd = 1'b0;
        state_d = ST_GUESS_DS;
      end
      ST_GUESS_DS: begin
        div_start = 1'b1;
        div_num   = mul_res[NUM_W-1:0];
        div_den   = DEN_W'(tab_den);
        state_d   = ST_GUESS_DW;
      end
      ST_GUESS_DW: begin
        if (div_done) begin
          state_d = ST_SLOPE0;
        end
      end
      ST_SLOPE0: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done) begin
          if (poly_val >= $signed(MUL_A_W'(minsl_q))) begin
            state_d = ST_NT_SLOPE;
          end else if (poly_val == '0) begin
            state_d = ST_Y_CURVE;
          end else begin
            state_d = ST_BI_CURVE;
          end
        end
      end
      ST_NT_SLOPE: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done) begin
          state_d = (poly_val == '0) ? ST_Y_CURVE : ST_NT_CURVE;
        end
      end
      ST_NT_CURVE: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done) begin
          if (cxv == '0) begin
            state_d = ST_Y_CURVE;
          end else begin
            div_start = 1'b1;
            state_d   = ST_NT_DW;
          end
        end
      end
      ST_NT_DW: begin
        if (div_done) begin
          state_d = (it_q == ITW'(NEWTON_ITERATIONS - 1)) ? ST_Y_CURVE : ST_NT_SLOPE;
        end
      end
      ST_BI_CURVE: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done && !bi_cont) begin
          state_d = ST_Y_CURVE;
        end
      end
      ST_Y_CURVE: begin
        ps_d = poly_done ? 2'd0 : ps_q + 2'd1;
        if (poly_done) begin
          state_d = ST_OUT_MUL;
        end
      end
      ST_OUT_MUL: begin
        mul_a   = MUL_A_W'(delta_q);
        mul_b   = y_q;
        state_d = ST_OUT_SUM;
      end
      ST_OUT_SUM: begin
        // hold the product steady while the previous beat is still waiting
        mul_a = MUL_A_W'(delta_q);
        mul_b = y_q;
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ps_q        <= 2'd0;
      out_valid_q <= 1'b0;
      tab_valid_q <= 1'b0;
      x1_q        <= '0;
      y1_q        <= '0;
      x2_q        <= ONE_X;
      y2_q        <= ONE_T;
      start_q     <= '0;
      delta_q     <= VAL_W'(ONE_INT);
      minsl_q     <= X_W'(66);
      prec_q      <= X_W'(1);
    end else begin
      state_q <= state_d;
      ps_q    <= ps_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        tab_valid_q <= 1'b0;
        unique case (cfg_idx_i)
          CFG_CTRL_X1:   x1_q    <= cfg_data_i[X_W-1:0];
          CFG_CTRL_Y1:   y1_q    <= cfg_data_i[Y_W-1:0];
          CFG_CTRL_X2:   x2_q    <= cfg_data_i[X_W-1:0];
          CFG_CTRL_Y2:   y2_q    <= cfg_data_i[Y_W-1:0];
          CFG_START:     start_q <= cfg_data_i[VAL_W-1:0];
          CFG_DELTA:     delta_q <= cfg_data_i[VAL_W-1:0];
          CFG_MIN_SLOPE: minsl_q <= cfg_data_i[X_W-1:0];
          CFG_PRECISION: prec_q  <= cfg_data_i[X_W-1:0];
          default: ;
        endcase
      end else if (tab_set) begin
        tab_valid_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tab_mem[idx_q] <= build_w;
    end
    rdata_q <= tab_mem[rd_addr];
    if (out_load) begin
      out_q <= result;
    end
    unique case (state_q)
      ST_IDLE: begin
        x_q   <= in_ch.progress;
        idx_q <= '0;
        g_q   <= '0;
        gr_q  <= '0;
      end
      ST_BUILD: begin
        if (poly_done) begin
          idx_q <= idx_q + IW'(1);
          g_q   <= g_next;
          gr_q  <= gr_next;
        end
      end
      ST_SCAN_RD: begin
        idx_q <= IW'(1);
        glo_q <= '0;
        g_q   <= X_W'(STEP_Q);
        gr_q  <= RW'(STEP_R);
      end
      ST_SCAN_PREV: prev_q <= rdata_q;
      ST_SCAN: begin
        if (idx_q == IW'(SAMPLE_COUNT - 1) || sample_gt) begin
          tab_lo_q <= prev_q;
          tab_hi_q <= rdata_q;
          lo_q     <= glo_q;
          hi_q     <= g_q;
        end else begin
          prev_q <= rdata_q;
          idx_q  <= idx_q + IW'(1);
          glo_q  <= g_q;
          g_q    <= g_next;
          gr_q   <= gr_next;
        end
      end
      ST_GUESS_DW: begin
        if (div_done) begin
          u_q <= guess;
        end
      end
      ST_SLOPE0: begin
        it_q <= '0;
        ba_q <= $signed({1'b0, lo_q});
        bb_q <= $signed({1'b0, hi_q});
        if (poly_done && poly_val < $signed(MUL_A_W'(minsl_q)) && poly_val != '0) begin
          u_q <= first_ct;
        end
      end
      ST_NT_SLOPE: begin
        if (poly_done) begin
          s_q <= poly_val[DEN_W-1:0];
        end
      end
      ST_NT_DW: begin
        if (div_done) begin
          u_q  <= u_new;
          it_q <= it_q + ITW'(1);
        end
      end
      ST_BI_CURVE: begin
        if (poly_done) begin
          ba_q <= na;
          bb_q <= nb;
          if (bi_cont) begin
            it_q <= it_q + ITW'(1);
            u_q  <= nct;
          end
        end
      end
      ST_Y_CURVE: begin
        if (poly_done) begin
          y_q <= poly_val[MUL_B_W-1:0];
        end
      end
      default: y_q <= y_q;
    endcase
  end

  assign in_ch.ready        = (state_q == ST_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.eased_value = out_q;

endmodule
